### design/rrbc_pkg.sv
// shared widths, command and area codes and the decode result type
`timescale 1ns / 1ps

package rrbc_pkg;

    localparam int CMD_W      = 2;
    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int ROM_IDX_W  = 21;
    localparam int ROM_SIZE_W = 22;
    localparam int ROM_BANK_W = 7;
    localparam int RAM_BANK_W = 8;
    localparam int RAM_IDX_W  = 15;

    localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd2;

    // address[15:13] areas
    localparam logic [2:0] AREA_RAM_EN   = 3'b000;
    localparam logic [2:0] AREA_ROM_BANK = 3'b001;
    localparam logic [2:0] AREA_RAM_BANK = 3'b010;
    localparam logic [2:0] AREA_RAM      = 3'b101;

    localparam logic [3:0]      RAM_EN_KEY = 4'hA;
    localparam logic [DATA_W-1:0] OPEN_BUS = 8'hFF;

    typedef struct packed {
        logic                  is_read;
        logic                  rom_ok;
        logic                  rom_we;
        logic [ROM_IDX_W-1:0]  rom_idx;
        logic                  ram_ok;
        logic                  ram_we;
        logic [RAM_IDX_W-1:0]  ram_idx;
        logic                  set_ram_on;
        logic                  ram_on_val;
        logic                  set_rom_bank;
        logic [ROM_BANK_W-1:0] rom_bank_val;
        logic                  set_ram_bank;
    } t_dec;

endpackage

### design/rrbc_in_if.sv
// input channel carrying bus reads, bus writes and rom load bytes
`timescale 1ns / 1ps

interface rrbc_in_if
    import rrbc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     cmd;
    logic [ADDR_W-1:0]    address;
    logic [DATA_W-1:0]    write_data;
    logic [ROM_IDX_W-1:0] rom_index;

    modport source (output valid, cmd, address, write_data, rom_index, input ready);
    modport sink   (input valid, cmd, address, write_data, rom_index, output ready);
endinterface

### design/rrbc_out_if.sv
// output channel carrying read data
`timescale 1ns / 1ps

interface rrbc_out_if
    import rrbc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;

    modport source (output valid, read_data, input ready);
    modport sink   (input valid, read_data, output ready);
endinterface

### design/rom_ram_bank_controller_top.sv
// cartridge rom/ram bank controller top level
`timescale 1ns / 1ps

// Takes one transaction per cycle while i_item.ready is high: bus reads, bus
// writes and rom load bytes. Each bus read gives one result, held first in
// the rom/ram read register and then in the output register; writes and
// loads give none and complete in the cycle they are accepted, so a read right
// after a write sees the new data. Sustained rate is one transaction per cycle
// while the result side keeps up. After reset the ram is swept to zero, one
// byte per cycle across the whole ram, and i_item.ready stays low meanwhile;
// rom_size writes are taken at any time. Rom contents survive reset.
module rom_ram_bank_controller_top
    import rrbc_pkg::*;
#(
    parameter int ROM_BYTES = 2097152,
    parameter int RAM_BYTES = 32768
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rrbc_in_if.sink               i_item,
    rrbc_out_if.source            o_result,
    input  logic                  i_cfg_we,
    input  logic [ROM_SIZE_W-1:0] i_cfg_wdata
);

    localparam int ROM_AW = $clog2(ROM_BYTES);
    localparam int RAM_AW = $clog2(RAM_BYTES);

    logic [DATA_W-1:0] rom_mem [ROM_BYTES];
    logic [DATA_W-1:0] ram_mem [RAM_BYTES];

    logic [ROM_SIZE_W-1:0] r_rom_size;
    logic [ROM_BANK_W-1:0] r_rom_bank;
    logic [RAM_BANK_W-1:0] r_ram_bank;
    logic                  r_ram_on;
    logic                  r_clr_busy;
    logic [RAM_AW-1:0]     r_clr_addr;
    logic [DATA_W-1:0]     r_rom_q;
    logic [DATA_W-1:0]     r_ram_q;
    logic                  r_s1_valid;
    logic                  r_s1_rom_ok;
    logic                  r_s1_ram_ok;
    logic                  r_out_valid;
    logic [DATA_W-1:0]     r_out_data;
    logic [DATA_W-1:0]     n_out_data;

    t_dec dec;
    logic s1_adv;
    logic acc;
    logic acc_rd;

    rrbc_decode #(
        .ROM_BYTES (ROM_BYTES),
        .RAM_BYTES (RAM_BYTES)
    ) u_decode (
        .i_cmd        (i_item.cmd),
        .i_address    (i_item.address),
        .i_write_data (i_item.write_data),
        .i_rom_index  (i_item.rom_index),
        .i_rom_size   (r_rom_size),
        .i_rom_bank   (r_rom_bank),
        .i_ram_bank   (r_ram_bank),
        .i_ram_on     (r_ram_on),
        .o_dec        (dec)
    );

    assign s1_adv       = !r_out_valid || o_result.ready;
    assign i_item.ready = !r_clr_busy && (!r_s1_valid || s1_adv);
    assign acc          = i_item.valid && i_item.ready;
    assign acc_rd       = acc && dec.is_read;

    assign o_result.valid     = r_out_valid;
    assign o_result.read_data = r_out_data;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_size <= '0;
            r_rom_bank <= ROM_BANK_W'(1);
            r_ram_bank <= '0;
            r_ram_on   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_rom_size <= i_cfg_wdata;
            end
            if (acc && dec.set_ram_on) begin
                r_ram_on <= dec.ram_on_val;
            end
            if (acc && dec.set_rom_bank) begin
                r_rom_bank <= dec.rom_bank_val;
            end
            if (acc && dec.set_ram_bank) begin
                r_ram_bank <= i_item.write_data;
            end
        end
    end

    // ram clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + RAM_AW'(1);
            if (r_clr_addr == RAM_AW'(RAM_BYTES - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // rom memory
    always_ff @(posedge i_clk) begin
        if (acc && dec.rom_we) begin
            rom_mem[dec.rom_idx[ROM_AW-1:0]] <= i_item.write_data;
        end else if (acc_rd) begin
            r_rom_q <= rom_mem[dec.rom_idx[ROM_AW-1:0]];
        end
    end

    // ram memory
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            ram_mem[r_clr_addr] <= '0;
        end else if (acc && dec.ram_we) begin
            ram_mem[dec.ram_idx[RAM_AW-1:0]] <= i_item.write_data;
        end else if (acc_rd) begin
            r_ram_q <= ram_mem[dec.ram_idx[RAM_AW-1:0]];
        end
    end

    // read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (acc_rd) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_rd) begin
            r_s1_rom_ok <= dec.rom_ok;
            r_s1_ram_ok <= dec.ram_ok;
        end
    end

    always_comb begin
        n_out_data = OPEN_BUS;
        if (r_s1_rom_ok) begin
            n_out_data = r_rom_q;
        end else if (r_s1_ram_ok) begin
            n_out_data = r_ram_q;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_out_data <= n_out_data;
        end
    end

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !i_item.ready)
        else $error("transaction accepted during ram clear");

    a_rom_bank_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rom_bank != '0)
        else $error("rom bank register holds zero");

    a_read_reaches_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_rd |=> r_s1_valid)
        else $error("accepted read lost before read stage");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> (r_s1_valid && $stable(r_rom_q) && $stable(r_ram_q)))
        else $error("stalled read stage changed");

endmodule

### design/rrbc_decode.sv
// address decode and bank mapping for one transaction
`timescale 1ns / 1ps

module rrbc_decode
    import rrbc_pkg::*;
#(
    parameter int ROM_BYTES = 2097152,
    parameter int RAM_BYTES = 32768
) (
    input  logic [CMD_W-1:0]      i_cmd,
    input  logic [ADDR_W-1:0]     i_address,
    input  logic [DATA_W-1:0]     i_write_data,
    input  logic [ROM_IDX_W-1:0]  i_rom_index,
    input  logic [ROM_SIZE_W-1:0] i_rom_size,
    input  logic [ROM_BANK_W-1:0] i_rom_bank,
    input  logic [RAM_BANK_W-1:0] i_ram_bank,
    input  logic                  i_ram_on,
    output t_dec                  o_dec
);

    localparam logic [ROM_SIZE_W-1:0] ROM_LIM = ROM_SIZE_W'(ROM_BYTES);
    localparam logic [RAM_IDX_W:0]    RAM_LIM = (RAM_IDX_W + 1)'(RAM_BYTES);

    logic                  is_read;
    logic                  is_write;
    logic                  is_load;
    logic [ROM_SIZE_W-1:0] limit;
    logic [ROM_IDX_W-1:0]  rd_idx;
    logic [RAM_IDX_W-1:0]  ram_idx;
    logic                  ram_acc;
    logic                  in_ram;
    logic [ROM_BANK_W-1:0] bank_w;

    always_comb begin
        is_read  = 1'b0;
        is_write = 1'b0;
        is_load  = 1'b0;
        unique case (i_cmd)
            CMD_READ:  is_read  = 1'b1;
            CMD_WRITE: is_write = 1'b1;
            CMD_LOAD:  is_load  = 1'b1;
            default: ;
        endcase
    end

    always_comb begin
        limit   = (i_rom_size > ROM_LIM) ? ROM_LIM : i_rom_size;
        rd_idx  = i_address[14] ? {i_rom_bank, i_address[13:0]}
                                : {{ROM_BANK_W{1'b0}}, i_address[13:0]};
        ram_idx = {i_ram_bank[1:0], i_address[12:0]};
        ram_acc = i_ram_on && (i_ram_bank[RAM_BANK_W-1:2] == '0)
                  && ({1'b0, ram_idx} < RAM_LIM);
        in_ram  = (i_address[15:13] == AREA_RAM);
        bank_w  = i_write_data[ROM_BANK_W-1:0];

        o_dec              = '0;
        o_dec.is_read      = is_read;
        o_dec.rom_idx      = is_load ? i_rom_index : rd_idx;
        o_dec.rom_ok       = is_read && !i_address[15] && ({1'b0, rd_idx} < limit);
        o_dec.rom_we       = is_load && ({1'b0, i_rom_index} < ROM_LIM);
        o_dec.ram_idx      = ram_idx;
        o_dec.ram_ok       = is_read && in_ram && ram_acc;
        o_dec.ram_we       = is_write && in_ram && ram_acc;
        o_dec.ram_on_val   = (i_write_data[3:0] == RAM_EN_KEY);
        o_dec.rom_bank_val = (bank_w == '0) ? ROM_BANK_W'(1) : bank_w;

        unique case (i_address[15:13])
            AREA_RAM_EN:   o_dec.set_ram_on   = is_write;
            AREA_ROM_BANK: o_dec.set_rom_bank = is_write;
            AREA_RAM_BANK: o_dec.set_ram_bank = is_write;
            default: ;
        endcase
    end

endmodule

### tb/sv/rom_ram_bank_controller_top_tb.sv
// testbench for the cartridge rom/ram bank controller with a self-contained bank predictor
`timescale 1ns / 1ps

module rom_ram_bank_controller_top_tb;
    import rrbc_pkg::*;

    localparam int ROM_BYTES     = 2097152;
    localparam int RAM_BYTES     = 32768;
    localparam int RAM_AW        = $clog2(RAM_BYTES);
    localparam int RAM_BANK_SIZE = 8192;
    localparam int MAX_RAM_BANK  = 3;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 8;
    localparam int STALL_LIMIT   = 100000;
    localparam int MAX_REPORTS   = 40;

    localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]     cmd;
        logic [ADDR_W-1:0]    address;
        logic [DATA_W-1:0]    write_data;
        logic [ROM_IDX_W-1:0] rom_index;
    } t_bus_op;

    typedef enum int {SINK_ALWAYS, SINK_PATTERN, SINK_RANDOM} t_sink_mode;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [ROM_SIZE_W-1:0] i_cfg_wdata;

    rrbc_in_if  item_if ();
    rrbc_out_if result_if ();

    rom_ram_bank_controller_top #(
        .ROM_BYTES(ROM_BYTES),
        .RAM_BYTES(RAM_BYTES)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_if),
        .o_result    (result_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // predicted cartridge state
    bit   [DATA_W-1:0]     rom_image [int];
    bit   [DATA_W-1:0]     ram_image [RAM_BYTES];
    logic [ROM_BANK_W-1:0] cur_rom_bank = ROM_BANK_W'(1);
    logic [RAM_BANK_W-1:0] cur_ram_bank = '0;
    logic                  pred_ram_on = 1'b0;
    logic [ROM_SIZE_W-1:0] rom_size_cfg = '0;

    // stimulus-side view, kept so that no unloaded rom byte is ever read
    bit                    gen_loaded [int];
    logic [ROM_BANK_W-1:0] gen_rom_bank = ROM_BANK_W'(1);
    int                    gen_rom_limit = 0;
    int                    phase_items;

    t_bus_op             pending_ops [$];
    logic [DATA_W-1:0]   expected_bytes [$];

    int         mismatch_count = 0;
    int         idle_cycles = 0;
    int         src_gap_max = 0;
    int         burst_left = 0;
    int         gap_left = 0;
    t_sink_mode sink_mode = SINK_ALWAYS;
    logic [15:0] stall_pattern = 16'hFFFF;
    int         pat_pos = 0;
    int         holds_wanted = 0;
    int         holds_started = 0;
    int         hold_left = 0;
    t_bus_op    taken_op;
    t_bus_op    next_op;
    logic [DATA_W-1:0] exp_byte;

    function automatic int rom_limit_of(logic [ROM_SIZE_W-1:0] size);
        return (int'(size) > ROM_BYTES) ? ROM_BYTES : int'(size);
    endfunction

    function automatic logic [DATA_W-1:0] predict_read(logic [ADDR_W-1:0] addr);
        logic [ROM_IDX_W-1:0] idx;
        int ram_at;
        if (!addr[15]) begin
            idx = addr[14] ? {cur_rom_bank, addr[13:0]} : {{ROM_BANK_W{1'b0}}, addr[13:0]};
            if (int'(idx) >= rom_limit_of(rom_size_cfg))
                return OPEN_BUS;
            return rom_image.exists(int'(idx)) ? rom_image[int'(idx)] : '0;
        end
        if (addr[15:13] == AREA_RAM && pred_ram_on && int'(cur_ram_bank) <= MAX_RAM_BANK) begin
            ram_at = int'(cur_ram_bank) * RAM_BANK_SIZE + int'(addr[12:0]);
            if (ram_at < RAM_BYTES)
                return ram_image[RAM_AW'(ram_at)];
        end
        return OPEN_BUS;
    endfunction

    function automatic void apply_bus_op(t_bus_op op);
        int ram_at;
        case (op.cmd)
            CMD_READ: expected_bytes.push_back(predict_read(op.address));
            CMD_WRITE: begin
                case (op.address[15:13])
                    AREA_RAM_EN:   pred_ram_on = (op.write_data[3:0] == RAM_EN_KEY);
                    AREA_ROM_BANK: cur_rom_bank = (op.write_data[6:0] == '0) ? ROM_BANK_W'(1)
                                                                             : op.write_data[6:0];
                    AREA_RAM_BANK: cur_ram_bank = op.write_data;
                    AREA_RAM: begin
                        ram_at = int'(cur_ram_bank) * RAM_BANK_SIZE + int'(op.address[12:0]);
                        if (pred_ram_on && int'(cur_ram_bank) <= MAX_RAM_BANK
                            && ram_at < RAM_BYTES)
                            ram_image[RAM_AW'(ram_at)] = op.write_data;
                    end
                    default: ;
                endcase
            end
            CMD_LOAD: if (int'(op.rom_index) < ROM_BYTES) rom_image[int'(op.rom_index)] = op.write_data;
            default: ;
        endcase
    endfunction

    function automatic void push_op(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr,
                                    logic [DATA_W-1:0] data, logic [ROM_IDX_W-1:0] idx);
        t_bus_op op;
        t_bus_op fill;
        logic [ROM_IDX_W-1:0] ridx;
        // a rom read below the limit must hit a loaded byte, so load it first
        if (cmd == CMD_READ && !addr[15]) begin
            ridx = addr[14] ? {gen_rom_bank, addr[13:0]} : {{ROM_BANK_W{1'b0}}, addr[13:0]};
            if (int'(ridx) < gen_rom_limit && !gen_loaded.exists(int'(ridx))) begin
                fill.cmd        = CMD_LOAD;
                fill.address    = ADDR_W'($urandom);
                fill.write_data = DATA_W'($urandom);
                fill.rom_index  = ridx;
                pending_ops.push_back(fill);
                gen_loaded[int'(ridx)] = 1'b1;
                phase_items++;
            end
        end
        if (cmd == CMD_WRITE && addr[15:13] == AREA_ROM_BANK)
            gen_rom_bank = (data[6:0] == '0) ? ROM_BANK_W'(1) : data[6:0];
        if (cmd == CMD_LOAD)
            gen_loaded[int'(idx)] = 1'b1;
        op.cmd        = cmd;
        op.address    = addr;
        op.write_data = data;
        op.rom_index  = idx;
        pending_ops.push_back(op);
        if (cmd == CMD_READ || cmd == CMD_LOAD)
            phase_items++;
        else if (cmd == CMD_WRITE && (addr[15:13] == AREA_RAM_EN || addr[15:13] == AREA_ROM_BANK
                 || addr[15:13] == AREA_RAM_BANK || addr[15:13] == AREA_RAM))
            phase_items++;
    endfunction

    function automatic logic [13:0] rom_offset();
        logic [13:0] off;
        int r;
        r = $urandom_range(0, 9);
        off = 14'($urandom);
        if (r < 4)
            off = 14'($urandom_range(0, 31));
        else if (r < 6)
            off = 14'h3FE0 + 14'($urandom_range(0, 31));
        return off;
    endfunction

    function automatic logic [12:0] ram_offset();
        logic [12:0] off;
        int r;
        r = $urandom_range(0, 9);
        off = 13'($urandom);
        if (r < 5)
            off = 13'($urandom_range(0, 15));
        else if (r < 7)
            off = 13'h1FF0 + 13'($urandom_range(0, 15));
        return off;
    endfunction

    function automatic void gen_random_read();
        int r;
        logic [ADDR_W-1:0] addr;
        r = $urandom_range(0, 99);
        addr = ADDR_W'($urandom);
        if (r < 30)
            addr = {2'b00, rom_offset()};
        else if (r < 60)
            addr = {2'b01, rom_offset()};
        else if (r < 85)
            addr = {AREA_RAM, ram_offset()};
        push_op(CMD_READ, addr, DATA_W'($urandom), ROM_IDX_W'($urandom));
    endfunction

    function automatic void gen_random_write();
        int r;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic [12:0] low;
        r = $urandom_range(0, 99);
        low = 13'($urandom);
        data = DATA_W'($urandom);
        if (r < 20) begin
            addr = {AREA_RAM_EN, low};
            if ($urandom_range(0, 9) < 7)
                data[3:0] = RAM_EN_KEY;
        end else if (r < 40) begin
            addr = {AREA_ROM_BANK, low};
            case ($urandom_range(0, 9))
                0: data = 8'h00;
                1: data = 8'h80;
                default: ;
            endcase
        end else if (r < 60) begin
            addr = {AREA_RAM_BANK, low};
            if ($urandom_range(0, 9) < 8)
                data = DATA_W'($urandom_range(0, MAX_RAM_BANK));
        end else if (r < 90) begin
            addr = {AREA_RAM, ram_offset()};
        end else if ($urandom_range(0, 1) == 0) begin
            addr = 16'h6000 + ADDR_W'($urandom_range(0, 16'h3FFF));
        end else begin
            addr = 16'hC000 + ADDR_W'($urandom_range(0, 16'h3FFF));
        end
        push_op(CMD_WRITE, addr, data, ROM_IDX_W'($urandom));
    endfunction

    function automatic void gen_random_load();
        int r;
        logic [ROM_IDX_W-1:0] idx;
        r = $urandom_range(0, 9);
        idx = ROM_IDX_W'($urandom);
        if (r < 4)
            idx = {{ROM_BANK_W{1'b0}}, rom_offset()};
        else if (r < 8)
            idx = {gen_rom_bank, rom_offset()};
        push_op(CMD_LOAD, ADDR_W'($urandom), DATA_W'($urandom), idx);
    endfunction

    function automatic void gen_random_step();
        int r;
        int n;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] bank;
        logic [12:0] off13;
        logic [13:0] off14;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            gen_random_read();
        end else if (r < 68) begin
            gen_random_write();
        end else if (r < 80) begin
            gen_random_load();
        end else if (r < 83) begin
            push_op(CMD_NONE, ADDR_W'($urandom), DATA_W'($urandom), ROM_IDX_W'($urandom));
        end else if (r < 93) begin
            // enable ram, pick a bank, write bytes and read them back
            key = DATA_W'($urandom);
            key[3:0] = RAM_EN_KEY;
            bank = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, MAX_RAM_BANK));
            push_op(CMD_WRITE, {AREA_RAM_EN, 13'($urandom)}, key, ROM_IDX_W'($urandom));
            push_op(CMD_WRITE, {AREA_RAM_BANK, 13'($urandom)}, bank, ROM_IDX_W'($urandom));
            n = $urandom_range(1, 4);
            repeat (n) begin
                off13 = ram_offset();
                push_op(CMD_WRITE, {AREA_RAM, off13}, DATA_W'($urandom), ROM_IDX_W'($urandom));
                push_op(CMD_READ, {AREA_RAM, off13}, DATA_W'($urandom), ROM_IDX_W'($urandom));
            end
        end else begin
            // switch rom bank, load bytes and read them through the bank window
            push_op(CMD_WRITE, {AREA_ROM_BANK, 13'($urandom)}, DATA_W'($urandom),
                    ROM_IDX_W'($urandom));
            n = $urandom_range(1, 4);
            repeat (n) begin
                off14 = rom_offset();
                push_op(CMD_LOAD, ADDR_W'($urandom), DATA_W'($urandom), {gen_rom_bank, off14});
                push_op(CMD_READ, {2'b01, off14}, DATA_W'($urandom), ROM_IDX_W'($urandom));
            end
        end
    endfunction

    task automatic settle();
        while (pending_ops.size() != 0 || item_if.valid || expected_bytes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic start_phase(input logic [ROM_SIZE_W-1:0] size, input int gap,
                               input t_sink_mode mode, input bit hold);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= size;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        rom_size_cfg  = size;
        gen_rom_limit = rom_limit_of(size);
        src_gap_max   = gap;
        sink_mode     = mode;
        stall_pattern = 16'($urandom) | 16'h8001;
        if (hold)
            holds_wanted++;
        phase_items = 0;
    endtask

    function automatic void fill_random(input int count);
        while (phase_items < count)
            gen_random_step();
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // sender: bursts of transactions separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_if.valid <= 1'b0;
        end else begin
            if (item_if.valid && item_if.ready) begin
                taken_op.cmd        = item_if.cmd;
                taken_op.address    = item_if.address;
                taken_op.write_data = item_if.write_data;
                taken_op.rom_index  = item_if.rom_index;
                apply_bus_op(taken_op);
            end
            if (!item_if.valid || item_if.ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    item_if.valid <= 1'b0;
                end else if (pending_ops.size() != 0) begin
                    next_op = pending_ops.pop_front();
                    item_if.valid      <= 1'b1;
                    item_if.cmd        <= next_op.cmd;
                    item_if.address    <= next_op.address;
                    item_if.write_data <= next_op.write_data;
                    item_if.rom_index  <= next_op.rom_index;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = (src_gap_max == 0) ? 0 : $urandom_range(0, src_gap_max);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    item_if.valid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern, random stalls and long holds
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            result_if.ready <= 1'b0;
        end else if (holds_started != holds_wanted) begin
            holds_started++;
            hold_left = HOLD_CYCLES;
            result_if.ready <= 1'b0;
        end else begin
            case (sink_mode)
                SINK_ALWAYS:  result_if.ready <= 1'b1;
                SINK_PATTERN: begin
                    result_if.ready <= stall_pattern[pat_pos[3:0]];
                    pat_pos++;
                end
                default:      result_if.ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // result check
    always @(posedge i_clk) begin
        if (i_rst_n && result_if.valid && result_if.ready) begin
            if (expected_bytes.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected read data, expected none, actual %02h",
                             $time, result_if.read_data);
            end else begin
                exp_byte = expected_bytes.pop_front();
                if (result_if.read_data !== exp_byte) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: read data mismatch, expected %02h, actual %02h",
                                 $time, exp_byte, result_if.read_data);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_wdata        = '0;
        item_if.valid      = 1'b0;
        item_if.cmd        = CMD_READ;
        item_if.address    = '0;
        item_if.write_data = '0;
        item_if.rom_index  = '0;
        result_if.ready    = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // no cartridge, ram enable and bank corner cases
        phase_items = 0;
        push_op(CMD_READ,  16'h0000, 8'h00, '0);
        push_op(CMD_READ,  16'h7FFF, 8'h00, '0);
        push_op(CMD_LOAD,  16'h0000, 8'h3C, 21'h000000);
        push_op(CMD_LOAD,  16'hFFFF, 8'hC3, 21'h1FFFFF);
        push_op(CMD_READ,  16'hA000, 8'h00, '0);
        push_op(CMD_WRITE, 16'h0000, 8'h0A, '0);
        push_op(CMD_READ,  16'hA000, 8'h00, '0);
        push_op(CMD_WRITE, 16'hA000, 8'h5A, '0);
        push_op(CMD_WRITE, 16'hBFFF, 8'hFF, '0);
        push_op(CMD_READ,  16'hA000, 8'h00, '0);
        push_op(CMD_WRITE, 16'h5FFF, 8'h04, '0);
        push_op(CMD_WRITE, 16'hB000, 8'h11, '0);
        push_op(CMD_READ,  16'hB000, 8'h00, '0);
        push_op(CMD_WRITE, 16'h4000, 8'h03, '0);
        push_op(CMD_WRITE, 16'hBFFF, 8'hA5, '0);
        push_op(CMD_READ,  16'hBFFF, 8'h00, '0);
        push_op(CMD_WRITE, 16'h2000, 8'h00, '0);
        push_op(CMD_WRITE, 16'h3FFF, 8'h80, '0);
        push_op(CMD_WRITE, 16'h6000, 8'hFF, '0);
        push_op(CMD_WRITE, 16'hFFFF, 8'hFF, '0);
        push_op(CMD_READ,  16'h8000, 8'h00, '0);
        push_op(CMD_READ,  16'hFFFF, 8'h00, '0);
        push_op(CMD_WRITE, 16'h1FFF, 8'hF0, '0);
        push_op(CMD_READ,  16'hBFFF, 8'h00, '0);
        push_op(CMD_NONE,  16'hFFFF, 8'hFF, 21'h1FFFFF);

        // oversized rom size, highest bank and bank zero read back
        start_phase(22'h3FFFFF, 6, SINK_RANDOM, 1'b0);
        push_op(CMD_WRITE, 16'h2000, 8'h7F, '0);
        push_op(CMD_READ,  16'h7FFF, 8'h00, '0);
        push_op(CMD_READ,  16'h0000, 8'h00, '0);
        push_op(CMD_READ,  16'h3FFF, 8'h00, '0);
        fill_random(150);

        start_phase(22'h200000, 0, SINK_ALWAYS, 1'b0);
        fill_random(150);

        start_phase(22'h008000, 3, SINK_PATTERN, 1'b1);
        fill_random(200);

        start_phase(22'h000001, 10, SINK_RANDOM, 1'b0);
        fill_random(100);

        start_phase(22'h000000, 2, SINK_PATTERN, 1'b1);
        fill_random(100);

        start_phase(22'($urandom_range(22'h004000, 22'h300000)), 4, SINK_RANDOM, 1'b0);
        fill_random(250);

        settle();
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### filelist.f
design/rrbc_pkg.sv
design/rrbc_in_if.sv
design/rrbc_out_if.sv
design/rrbc_decode.sv
design/rom_ram_bank_controller_top.sv
tb/sv/rom_ram_bank_controller_top_tb.sv
